// ===== design/sjis_pkg.sv =====
// ----------------------------------------------------------------------------
// sjis_pkg
// shared types, constants and the shift-jis to jis code conversion
// ----------------------------------------------------------------------------
package sjis_pkg;

	localparam int unsigned SCREEN_WIDTH = 80;

	localparam logic [7:0] LEAD1_LO    = 8'h81;
	localparam logic [7:0] LEAD1_HI    = 8'h9F;
	localparam logic [7:0] LEAD2_LO    = 8'hE0;
	localparam logic [7:0] LEAD2_HI    = 8'hFC;
	localparam logic [7:0] ROW_OFS1    = 8'h71;
	localparam logic [7:0] ROW_OFS2    = 8'hB1;
	localparam logic [7:0] TRAIL_GAP   = 8'h7F;
	localparam logic [7:0] TRAIL_SPLIT = 8'h9E;
	localparam logic [7:0] CELL_OFS2   = 8'h7D;
	localparam logic [7:0] CELL_OFS1   = 8'h1F;
	localparam logic [7:0] JIS_BIAS    = 8'h20;
	localparam logic [7:0] BLANK_CHAR  = 8'h20;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_KANJI  = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	// renderer state carried between items
	typedef struct packed {
		logic [6:0] column;
		logic [7:0] row;
		logic [7:0] attr;
		logic [7:0] lead;
		logic       lead_pending;
		logic       stopped;
	} state_t;

	// one input item
	typedef struct packed {
		logic       first_byte;
		logic [6:0] start_column;
		logic [7:0] row;
		logic [7:0] attribute;
		logic [7:0] text_byte;
	} item_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [6:0]  column;
		logic [7:0]  row;
		logic [7:0]  char_code;
		logic [15:0] jis_code;
		logic [7:0]  attr;
	} result_t;

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
	endfunction

	// 8-bit wrapping conversion; a ninth bit of the cell value lands in the row byte
	function automatic logic [15:0] to_jis(input logic [7:0] lead, input logic [7:0] trail);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [8:0] jr;
		logic [8:0] jc;
		hi = lead - ((lead <= LEAD1_HI) ? ROW_OFS1 : ROW_OFS2);
		hi = {hi[6:0], 1'b0} + 8'd1;
		lo = trail;
		if (lo > TRAIL_GAP) begin
			lo = lo - 8'd1;
		end
		if (lo >= TRAIL_SPLIT) begin
			lo = lo - CELL_OFS2;
			hi = hi + 8'd1;
		end else begin
			lo = lo - CELL_OFS1;
		end
		jr = {1'b0, hi} + {1'b0, JIS_BIAS};
		jc = {1'b0, lo} + {1'b0, JIS_BIAS};
		return {jr[7:0], 8'h00} | {7'h00, jc};
	endfunction

endpackage

// ===== design/sjis_text_row_renderer_core.sv =====
// ----------------------------------------------------------------------------
// sjis_text_row_renderer_core
// renders a zero-terminated shift-jis byte string onto one screen row
// ----------------------------------------------------------------------------
// a result passes the input register, then the result register
// throughput: one text byte per cycle unless the output stalls; state update is in sjis_step
// items that give no result (lead bytes, clipped bytes) never wait on the output side
// reset: arst_n low clears both valid flags and the renderer state
// (column 0, row 0, attribute 0, no pending lead, not stopped)
module sjis_text_row_renderer_core import sjis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// start_column[6:0], row[14:7], attribute[22:15], text_byte[30:23], zero pad
	input  logic [31:0] s_tdata,
	// first_byte[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_column[6:0], cell_row[14:7], char_code[22:15], jis_code[38:23],
	// cell_attribute[46:39], zero pad
	output logic [47:0] m_tdata,
	// result_kind[1:0]
	output logic [1:0]  m_tuser
);

	// input register
	logic    valid_s1;
	item_t   item_s1;

	// renderer state, updated as an item leaves stage one
	state_t  state_q;
	state_t  state_next;

	// result register
	logic    valid_s2;
	result_t res_s2;

	logic    res_valid;
	result_t res;
	logic    advance;

	// stage one moves on when the result register is free or being drained;
	// items without a result never wait on the output side
	assign advance  = valid_s1 && (!valid_s2 || m_tready || !res_valid);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.first_byte   <= s_tuser;
			item_s1.start_column <= s_tdata[6:0];
			item_s1.row          <= s_tdata[14:7];
			item_s1.attribute    <= s_tdata[22:15];
			item_s1.text_byte    <= s_tdata[30:23];
		end
	end

	sjis_step u_step (
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register: load on a new result, clear when taken with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {1'b0, res_s2.attr, res_s2.jis_code, res_s2.char_code,
		res_s2.row, res_s2.column};

`ifndef NO_ASSERTIONS
	// a kanji result always fits both of its cells on the row
	a_kanji_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_DONE) || !m_tvalid || m_tuser != KIND_KANJI ||
		({1'b0, m_tdata[6:0]} + 8'd1 < 8'(SCREEN_WIDTH)))
		else $error("kanji result crosses the last column");

	// a done result leaves the renderer stopped with no pending lead
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res.kind == KIND_DONE) |=>
		(state_q.stopped && !state_q.lead_pending))
		else $error("state not stopped after terminator");

	// an item held in stage one is never dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled item lost from input register");

	// a result is only overwritten once the old one has been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |-> (!valid_s2 || m_tready))
		else $error("result register overwritten");
`endif

endmodule

// ===== design/sjis_step.sv =====
// ----------------------------------------------------------------------------
// sjis_step
// next-state and result logic for one text byte
// ----------------------------------------------------------------------------
module sjis_step import sjis_pkg::*; (
	input  state_t  state,
	input  item_t   item,
	output state_t  state_next,
	output logic    res_valid,
	output result_t res
);

	always_comb begin
		state_t     s;
		logic [7:0] col_p1;
		s = state;
		if (item.first_byte) begin
			s.column       = item.start_column;
			s.row          = item.row;
			s.attr         = item.attribute;
			s.lead_pending = 1'b0;
			s.stopped      = 1'b0;
		end
		col_p1 = {1'b0, s.column} + 8'd1;

		res_valid     = 1'b0;
		res.kind      = KIND_SINGLE;
		res.column    = s.column;
		res.row       = s.row;
		res.char_code = 8'h00;
		res.jis_code  = 16'h0000;
		res.attr      = s.attr;

		if (item.text_byte == 8'h00) begin
			// terminator drops any pending lead
			s.lead_pending = 1'b0;
			s.stopped      = 1'b1;
			res_valid      = 1'b1;
			res.kind       = KIND_DONE;
		end else if (s.stopped) begin
			res_valid = 1'b0;
		end else if (s.lead_pending) begin
			s.lead_pending = 1'b0;
			res_valid      = 1'b1;
			if (col_p1 < 8'(SCREEN_WIDTH)) begin
				res.kind     = KIND_KANJI;
				res.jis_code = to_jis(s.lead, item.text_byte);
				s.column     = s.column + 7'd2;
			end else begin
				// kanji would cross the last column
				res.char_code = BLANK_CHAR;
				s.column      = s.column + 7'd1;
			end
		end else if ({1'b0, s.column} >= 8'(SCREEN_WIDTH)) begin
			s.stopped = 1'b1;
		end else if (is_lead(item.text_byte)) begin
			s.lead         = item.text_byte;
			s.lead_pending = 1'b1;
		end else begin
			res_valid     = 1'b1;
			res.char_code = item.text_byte;
			s.column      = s.column + 7'd1;
		end
		state_next = s;
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the shift-jis row renderer: a directed script of
// corner bytes, then random strings under three idle/stall profiles, with
// every result item scored against a cycle-free model of the renderer
// ----------------------------------------------------------------------------
module tb;
	import sjis_pkg::*;

	// one text byte as it goes in
	typedef struct {
		bit         first;
		logic [6:0] scol;
		logic [7:0] row;
		logic [7:0] attr;
		logic [7:0] tbyte;
	} text_item_t;

	// one cell write as it comes out
	typedef struct {
		kind_t       kind;
		logic [6:0]  col;
		logic [7:0]  row;
		logic [7:0]  ch;
		logic [15:0] jis;
		logic [7:0]  attr;
	} cell_write_t;

	// directed step: the result is typed in when known is set
	typedef struct {
		text_item_t  item;
		bit          known;
		bit          has_res;
		cell_write_t want;
	} script_row_t;

	localparam int ITEMS_PER_PHASE = 475;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	int errors = 0;
	int items_sent = 0;
	int send_idle = 0;
	int recv_stall = 0;

	cell_write_t pending_writes[$];
	script_row_t script [25];

	// model copy of the renderer state
	logic [6:0] cur_col = '0;
	logic [7:0] cur_row = '0;
	logic [7:0] cur_attr = '0;
	logic [7:0] held_lead = '0;
	bit         lead_held = 1'b0;
	bit         halted = 1'b0;

	sjis_text_row_renderer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shift-jis pair to jis row/cell, all in 8-bit wrapping steps
	function automatic logic [15:0] sjis_pair_to_jis(input logic [7:0] lead,
			input logic [7:0] trail);
		logic [7:0] r;
		logic [7:0] c;
		logic [8:0] jr;
		logic [8:0] jc;
		r = lead - ((lead <= LEAD1_HI) ? ROW_OFS1 : ROW_OFS2);
		r = (r << 1) + 8'd1;
		c = trail;
		if (c > TRAIL_GAP) begin
			c = c - 8'd1;
		end
		if (c >= TRAIL_SPLIT) begin
			c = c - CELL_OFS2;
			r = r + 8'd1;
		end else begin
			c = c - CELL_OFS1;
		end
		jr = {1'b0, r} + {1'b0, JIS_BIAS};
		jc = {1'b0, c} + {1'b0, JIS_BIAS};
		// a carry out of the cell lands in the row byte
		return {jr[7:0] | {7'd0, jc[8]}, jc[7:0]};
	endfunction

	// advance the model by one byte; returns 1 when a cell write comes out
	function automatic bit render_byte(input text_item_t it, output cell_write_t res);
		if (it.first) begin
			cur_col = it.scol;
			cur_row = it.row;
			cur_attr = it.attr;
			lead_held = 1'b0;
			halted = 1'b0;
		end
		res.kind = KIND_SINGLE;
		res.col = cur_col;
		res.row = cur_row;
		res.ch = '0;
		res.jis = '0;
		res.attr = cur_attr;
		if (it.tbyte == 8'h00) begin
			lead_held = 1'b0;
			halted = 1'b1;
			res.kind = KIND_DONE;
			return 1'b1;
		end
		if (halted) begin
			return 1'b0;
		end
		if (lead_held) begin
			lead_held = 1'b0;
			if (int'(cur_col) + 1 < SCREEN_WIDTH) begin
				res.kind = KIND_KANJI;
				res.jis = sjis_pair_to_jis(held_lead, it.tbyte);
				cur_col = cur_col + 7'd2;
			end else begin
				res.ch = BLANK_CHAR;
				cur_col = cur_col + 7'd1;
			end
			return 1'b1;
		end
		if (int'(cur_col) >= SCREEN_WIDTH) begin
			halted = 1'b1;
			return 1'b0;
		end
		if ((it.tbyte >= LEAD1_LO && it.tbyte <= LEAD1_HI) ||
				(it.tbyte >= LEAD2_LO && it.tbyte <= LEAD2_HI)) begin
			held_lead = it.tbyte;
			lead_held = 1'b1;
			return 1'b0;
		end
		res.ch = it.tbyte;
		cur_col = cur_col + 7'd1;
		return 1'b1;
	endfunction

	function automatic script_row_t plain_row(input bit first, input logic [6:0] scol,
			input logic [7:0] row, input logic [7:0] attr, input logic [7:0] b);
		script_row_t r;
		r.item = '{first, scol, row, attr, b};
		r.known = 1'b0;
		r.has_res = 1'b0;
		r.want = '{KIND_SINGLE, 7'd0, 8'd0, 8'd0, 16'd0, 8'd0};
		return r;
	endfunction

	function automatic script_row_t known_row(input bit first, input logic [6:0] scol,
			input logic [7:0] row, input logic [7:0] attr, input logic [7:0] b,
			input bit has_res, input kind_t kind, input logic [6:0] col,
			input logic [7:0] crow, input logic [7:0] ch, input logic [7:0] cattr);
		script_row_t r;
		r = plain_row(first, scol, row, attr, b);
		r.known = 1'b1;
		r.has_res = has_res;
		r.want = '{kind, col, crow, ch, 16'd0, cattr};
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		end
	endtask

	// queue the prediction, then present the byte until it is taken
	task automatic feed_byte(input text_item_t it, input bit known, input bit has_res,
			input cell_write_t want);
		cell_write_t pred;
		bit gives;
		gives = render_byte(it, pred);
		if (known) begin
			gives = has_res;
			pred = want;
		end
		if (gives) begin
			pending_writes.push_back(pred);
		end
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.first;
		s_tdata <= {1'b0, it.tbyte, it.attr, it.row, it.scol};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// hold the input side until every queued write has been seen
	task automatic drain_writes();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_writes.size() != 0);
	endtask

	// one random string: mostly well-formed text, sometimes left unterminated
	task automatic feed_string();
		text_item_t it;
		cell_write_t none;
		int len;
		int pick;
		bit want_trail;
		none = '{KIND_SINGLE, 7'd0, 8'd0, 8'd0, 16'd0, 8'd0};
		want_trail = 1'b0;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
		for (int k = 0; k <= len; k++) begin
			it.first = (k == 0);
			it.row = 8'($urandom);
			it.attr = 8'($urandom);
			it.scol = 7'($urandom_range(0, 127));
			if (k == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					it.scol = 7'($urandom_range(0, SCREEN_WIDTH));
				end else if (pick < 85) begin
					it.scol = 7'($urandom_range(SCREEN_WIDTH - 10, SCREEN_WIDTH));
				end
			end
			if (k == len) begin
				it.tbyte = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			end else if (want_trail) begin
				it.tbyte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
					8'($urandom_range(8'h40, 8'hFC));
				want_trail = 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					it.tbyte = 8'($urandom_range(8'h20, 8'h7E));
				end else if (pick < 75) begin
					it.tbyte = $urandom_range(0, 1) ? 8'($urandom_range(LEAD1_LO, LEAD1_HI)) :
						8'($urandom_range(LEAD2_LO, LEAD2_HI));
					want_trail = 1'b1;
				end else begin
					it.tbyte = 8'($urandom_range(1, 255));
				end
			end
			feed_byte(it, 1'b0, 1'b0, none);
		end
	endtask

	// result side: random stalls, each taken item scored against the oldest prediction
	always @(posedge clk) begin
		cell_write_t exp_w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d data 0x%0h",
						m_tuser, m_tdata));
				end else begin
					exp_w = pending_writes.pop_front();
					check_field("kind", 16'(m_tuser), 16'(exp_w.kind));
					check_field("column", 16'(m_tdata[6:0]), 16'(exp_w.col));
					check_field("row", 16'(m_tdata[14:7]), 16'(exp_w.row));
					check_field("char", 16'(m_tdata[22:15]), 16'(exp_w.ch));
					check_field("jis", m_tdata[38:23], exp_w.jis);
					check_field("attr", 16'(m_tdata[46:39]), 16'(exp_w.attr));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	initial begin
		cell_write_t none;
		text_item_t noise;
		none = '{KIND_SINGLE, 7'd0, 8'd0, 8'd0, 16'd0, 8'd0};

		script = '{
			// plain byte straight out of reset draws with zero column, row, attribute
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h41, 1'b1, KIND_SINGLE, 7'd0, 8'h00, 8'h41, 8'h00),
			known_row(1'b1, 7'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, KIND_SINGLE, 7'd0, 8'hFF, 8'hFF, 8'hFF),
			// lead range edges paired with trails around the split points
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h81, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h40),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h9F, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h9E),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'hE0, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h7F),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'hFC, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			// trail that itself sits in the lead range
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'hFC),
			// bytes just outside the lead ranges draw as single cells
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h80),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'hFD),
			// lead followed by the terminator is dropped
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h88, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h00),
			// after done: text is ignored, another zero repeats done
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h41, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h00),
			// kanji at the last column is clipped to a blank, then the row is full
			known_row(1'b1, 7'd79, 8'h05, 8'h07, 8'h82, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h60, 1'b1, KIND_SINGLE, 7'd79, 8'h05, BLANK_CHAR, 8'h07),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h41, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 7'd80, 8'h05, 8'h00, 8'h07),
			// start column past the width stops at once
			known_row(1'b1, 7'd127, 8'hAA, 8'h55, 8'h41, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 7'd127, 8'hAA, 8'h00, 8'h55),
			// kanji that just fits in the last two columns
			known_row(1'b1, 7'd78, 8'h3C, 8'hC3, 8'h81, 1'b0, KIND_SINGLE, 7'd0, 8'h00, 8'h00, 8'h00),
			plain_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h40),
			known_row(1'b0, 7'd0, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 7'd80, 8'h3C, 8'h00, 8'hC3)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 25; i++) begin
			feed_byte(script[i].item, script[i].known, script[i].has_res, script[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 11;
					recv_stall = 76;
				end
				1: begin
					send_idle = 76;
					recv_stall = 11;
				end
				default: begin
					send_idle = 0;
					recv_stall = 0;
				end
			endcase
			drain_writes();
			while (items_sent < 25 + ITEMS_PER_PHASE * (ph + 1)) begin
				if ($urandom_range(0, 99) < 8) begin
					// stray byte with random framing
					noise.first = 1'($urandom_range(0, 1));
					noise.scol = 7'($urandom_range(0, 127));
					noise.row = 8'($urandom);
					noise.attr = 8'($urandom);
					noise.tbyte = 8'($urandom);
					feed_byte(noise, 1'b0, 1'b0, none);
				end else begin
					feed_string();
				end
				if ($urandom_range(0, 99) < 3) begin
					drain_writes();
				end
			end
		end

		drain_writes();
		repeat (10) @(posedge clk);
		if (pending_writes.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_writes.size()));
		end
		if (errors == 0) begin
			$display("sjis_text_row_renderer_core regression: pass");
		end else begin
			$display("sjis_text_row_renderer_core regression: fail");
		end
		$finish;
	end

	// watchdog far past the slowest legal run
	initial begin
		#400000;
		$display("sjis_text_row_renderer_core regression: fail");
		$finish;
	end

endmodule
